// File: hdl/cdb_pkg.sv
// Shared types and constants for the clipped decimating blit.
// Used by clipped_decimating_blit_top and its checker; no dependencies.
package cdb_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_DEST_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ZOOM_FACTOR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE   = 3'd5;

  localparam logic [10:0] CNT_MAX    = 11'h7FF;
  localparam logic [11:0] SIZE_MAX   = 12'd2048;
  localparam logic [4:0]  FACTOR_MAX = 5'd16;

  typedef struct packed {
    logic [15:0] pixel_color;
    logic        start_of_image;
  } in_t;

  typedef struct packed {
    logic [19:0] write_address;
    logic [15:0] write_color;
  } out_t;

endpackage

// File: hdl/clipped_decimating_blit_top.sv
// Clipped, decimating 2D blit: pixel stream in, frame buffer writes out.
// Depends on cdb_pkg (payload structs, register indexes, limits).
//
// Usage
//   in_*  : source pixels in raster order, one per transaction. Set
//           start_of_image on the first pixel of each image; it clears the
//           position counters before that pixel is handled.
//   out_* : one write transaction (address, colour) per pixel that survives
//           clipping and decimation; clipped or skipped pixels give nothing.
//   cfg_* : register writes, index 0..5 = dest_x, dest_y, source width,
//           image_height, zoom_factor, row stride. cfg_ready is always
//           high; write only while no pixel is in flight.
// Timing
//   One pixel per cycle sustained while in_ready is high. A surviving pixel is
//   registered in out_r, or in the skid buffer if a stalled sink holds out_r. All
//   decision and address logic is a single pass between the position registers
//   and the output register; the critical path is the clipped row offset * row
//   stride product (11 x 12 bits) plus the address adds.
// Stall
//   Behind the output register sits a one-entry skid buffer. While the sink
//   stalls, one further result is absorbed; once the skid is full in_ready
//   drops until out_ready returns.
// Reset
//   rst_n (synchronous, active low) clears all position state, empties the
//   output stages and loads register defaults (origin 0,0, 1x1 image,
//   factor 1, row stride 480).
module clipped_decimating_blit_top
  import cdb_pkg::*;
#(
  parameter int unsigned DISPLAY_WIDTH  = 480,
  parameter int unsigned DISPLAY_HEIGHT = 480
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  // write output
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers, raw bits as written
  logic [11:0] dest_x_r, dest_y_r, src_w_r, image_height_r, stride_r;
  logic [4:0]  zoom_factor_r;

  // position state
  logic [10:0] src_col_r, src_row_r, dcc_r, drc_r;
  logic [3:0]  cph_r, rph_r;
  logic [19:0] row_base_r;
  logic [10:0] src_col_nxt, src_row_nxt, dcc_nxt, drc_nxt;
  logic [3:0]  cph_nxt, rph_nxt;
  logic [19:0] row_base_nxt;

  // output register and skid buffer
  logic out_v_r, skid_v_r;
  out_t out_r, skid_r;

  // derived configuration
  logic        dx_neg, dy_neg;
  logic [11:0] fx, fy;
  logic [10:0] tx, ty;
  logic [11:0] w, h;
  logic [4:0]  f;
  logic signed [13:0] len_img, len_disp, row_len;

  // current position (cleared by start_of_image)
  logic [10:0] cur_col, cur_row, cur_dcc, cur_drc;
  logic [3:0]  cur_cph, cur_rph;
  logic [19:0] cur_base;

  logic        col_in, row_in, hit, col_last, row_last;
  logic [12:0] right_pos, bottom_pos;
  logic [22:0] prod;
  logic [19:0] addr;
  logic        in_acc, push, pop;

  assign cfg_ready = 1'b1;
  assign in_ready  = ~skid_v_r;
  assign in_acc    = in_valid & in_ready;
  assign out_valid = out_v_r;
  assign out_data  = out_r;
  assign pop       = out_v_r & out_ready;
  assign push      = in_acc & hit;

  // clip limits from the signed origin
  always_comb begin
    dx_neg = dest_x_r[11];
    dy_neg = dest_y_r[11];
    fx = dx_neg ? 12'(13'd0 - {1'b1, dest_x_r}) : 12'd0;
    fy = dy_neg ? 12'(13'd0 - {1'b1, dest_y_r}) : 12'd0;
    tx = dx_neg ? 11'd0 : dest_x_r[10:0];
    ty = dy_neg ? 11'd0 : dest_y_r[10:0];

    if (src_w_r == 12'd0)       w = 12'd1;
    else if (src_w_r > SIZE_MAX) w = SIZE_MAX;
    else                        w = src_w_r;

    if (image_height_r == 12'd0)       h = 12'd1;
    else if (image_height_r > SIZE_MAX) h = SIZE_MAX;
    else                               h = image_height_r;

    if (zoom_factor_r == 5'd0)            f = 5'd1;
    else if (zoom_factor_r > FACTOR_MAX)  f = FACTOR_MAX;
    else                                  f = zoom_factor_r;

    len_img  = $signed({2'b00, w}) - $signed({2'b00, fx});
    len_disp = $signed(14'(DISPLAY_WIDTH)) - $signed({3'b000, tx});
    row_len  = (len_disp < len_img) ? len_disp : len_img;
    if (row_len < 0) row_len = 14'sd0;
  end

  // decision, address and next position
  always_comb begin
    if (in_data.start_of_image) begin
      cur_col  = '0;
      cur_row  = '0;
      cur_dcc  = '0;
      cur_drc  = '0;
      cur_cph  = '0;
      cur_rph  = '0;
      cur_base = '0;
    end else begin
      cur_col  = src_col_r;
      cur_row  = src_row_r;
      cur_dcc  = dcc_r;
      cur_drc  = drc_r;
      cur_cph  = cph_r;
      cur_rph  = rph_r;
      cur_base = row_base_r;
    end

    col_in     = {1'b0, cur_col} >= fx;
    row_in     = {1'b0, cur_row} >= fy;
    right_pos  = {2'b00, tx} + {2'b00, cur_dcc};
    bottom_pos = {2'b00, ty} + {2'b00, cur_drc};

    hit = col_in && row_in && (cur_cph == 4'd0) && (cur_rph == 4'd0) &&
          ($signed({3'b000, cur_dcc}) < row_len) &&
          (right_pos < {1'b0, stride_r}) &&
          (bottom_pos < 13'(DISPLAY_HEIGHT));

    prod = 23'(ty) * 23'(stride_r);
    addr = prod[19:0] + cur_base + 20'(tx) + 20'(cur_dcc);

    src_col_nxt  = cur_col;
    src_row_nxt  = cur_row;
    dcc_nxt      = cur_dcc;
    drc_nxt      = cur_drc;
    cph_nxt      = cur_cph;
    rph_nxt      = cur_rph;
    row_base_nxt = cur_base;

    if (col_in) begin
      if (cur_cph == 4'd0 && cur_dcc != CNT_MAX) dcc_nxt = cur_dcc + 11'd1;
      cph_nxt = (({1'b0, cur_cph} + 5'd1) >= f) ? 4'd0 : cur_cph + 4'd1;
    end

    col_last = ({1'b0, cur_col} + 12'd1) >= w;
    row_last = ({1'b0, cur_row} + 12'd1) >= h;

    if (col_last) begin
      src_col_nxt = '0;
      cph_nxt     = '0;
      dcc_nxt     = '0;
      if (row_in) begin
        if (cur_rph == 4'd0) begin
          if (cur_drc != CNT_MAX) drc_nxt = cur_drc + 11'd1;
          row_base_nxt = cur_base + {8'd0, stride_r};
        end
        rph_nxt = (({1'b0, cur_rph} + 5'd1) >= f) ? 4'd0 : cur_rph + 4'd1;
      end
      if (row_last) begin
        // end of image: wrap everything as for a fresh image
        src_row_nxt  = '0;
        drc_nxt      = '0;
        rph_nxt      = '0;
        row_base_nxt = '0;
      end else begin
        src_row_nxt = cur_row + 11'd1;
      end
    end else begin
      src_col_nxt = cur_col + 11'd1;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_x_r       <= 12'd0;
      dest_y_r       <= 12'd0;
      src_w_r        <= 12'd1;
      image_height_r <= 12'd1;
      zoom_factor_r  <= 5'd1;
      stride_r       <= 12'd480;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEST_X:       dest_x_r       <= cfg_data;
        CFG_DEST_Y:       dest_y_r       <= cfg_data;
        CFG_SRC_WIDTH:    src_w_r        <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_data;
        CFG_ZOOM_FACTOR:  zoom_factor_r  <= cfg_data[4:0];
        CFG_ROW_STRIDE:   stride_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // position state advances once per input transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r  <= '0;
      src_row_r  <= '0;
      dcc_r      <= '0;
      drc_r      <= '0;
      cph_r      <= '0;
      rph_r      <= '0;
      row_base_r <= '0;
    end else if (in_acc) begin
      src_col_r  <= src_col_nxt;
      src_row_r  <= src_row_nxt;
      dcc_r      <= dcc_nxt;
      drc_r      <= drc_nxt;
      cph_r      <= cph_nxt;
      rph_r      <= rph_nxt;
      row_base_r <= row_base_nxt;
    end
  end

  // output register with one-entry skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_v_r || pop) out_v_r  <= 1'b1;
      else                 skid_v_r <= 1'b1;
    end else if (pop) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) out_r <= skid_r;
    end else if (push) begin
      if (!out_v_r || pop) begin
        out_r.write_address <= addr;
        out_r.write_color   <= in_data.pixel_color;
      end else begin
        skid_r.write_address <= addr;
        skid_r.write_color   <= in_data.pixel_color;
      end
    end
  end

endmodule

// File: hdl/cdb_checker.sv
// Port-level checker for clipped_decimating_blit_top, bound to every instance.
// Depends on cdb_pkg and on the top level's port list.
module cdb_checker
  import cdb_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // stalled write transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("output transaction changed while stalled");

  // output stages empty straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_valid && in_ready))
    else $error("output not empty after reset");

  // input only blocked when the output is full
  a_block_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("in_ready low with no pending output");

  // one drained transaction frees the input
  a_unblock: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_ready && out_ready) |=> in_ready)
    else $error("input still blocked after output drained");

endmodule

bind clipped_decimating_blit_top cdb_checker u_cdb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: test/tb_blit_pkg.sv
`timescale 1ns / 1ps
// Frame buffer write tracker for the clipped decimating blit testbench.
// Depends on cdb_pkg for the payload structs, register indexes and limits.
package tb_blit_pkg;
  import cdb_pkg::*;

  localparam int DISP_W = 480;
  localparam int DISP_H = 480;

  // Sizes of 0 act as 1, anything above 2048 saturates.
  function automatic int clamp_size(logic [11:0] v);
    if (v == 12'd0) return 1;
    if (v > SIZE_MAX) return int'(SIZE_MAX);
    return int'(v);
  endfunction

  function automatic int clamp_zoom(logic [4:0] v);
    if (v == 5'd0) return 1;
    if (v > FACTOR_MAX) return int'(FACTOR_MAX);
    return int'(v);
  endfunction

  class blit_write_tracker;
    // register copies
    logic [11:0] org_x, org_y, img_w, img_h, stride;
    logic [4:0]  zoom;
    // raster position and decimation state
    logic [10:0] col, row, kept_cols, kept_rows;
    logic [3:0]  col_phase, row_phase;
    logic [19:0] row_base;

    out_t        expected_writes[$];
    int unsigned errors;

    function new();
      org_x  = 12'd0;
      org_y  = 12'd0;
      img_w  = 12'd1;
      img_h  = 12'd1;
      zoom   = 5'd1;
      stride = 12'd480;
      errors = 0;
      clear_position();
    endfunction

    function void clear_position();
      col       = '0;
      row       = '0;
      col_phase = '0;
      row_phase = '0;
      kept_cols = '0;
      kept_rows = '0;
      row_base  = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_DEST_X:       org_x  = val;
        CFG_DEST_Y:       org_y  = val;
        CFG_SRC_WIDTH:    img_w  = val;
        CFG_IMAGE_HEIGHT: img_h  = val;
        CFG_ZOOM_FACTOR:  zoom   = val[4:0];
        CFG_ROW_STRIDE:   stride = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_writes.size();
    endfunction

    // Advance the position state by one accepted pixel and queue the write
    // it should cause, if any.
    function void accept_pixel(in_t px);
      int   dx, dy, fx, fy, tx, ty, w, h, f, span, addr;
      bit   col_in, row_in;
      out_t wr;
      dx = $signed(org_x);
      dy = $signed(org_y);
      fx = (dx < 0) ? -dx : 0;
      fy = (dy < 0) ? -dy : 0;
      tx = (dx > 0) ? dx : 0;
      ty = (dy > 0) ? dy : 0;
      w  = clamp_size(img_w);
      h  = clamp_size(img_h);
      f  = clamp_zoom(zoom);
      span = w - fx;
      if (DISP_W - tx < span) span = DISP_W - tx;
      if (span < 0) span = 0;

      if (px.start_of_image) clear_position();

      col_in = int'(col) >= fx;
      row_in = int'(row) >= fy;

      if (col_in && row_in && col_phase == 4'd0 && row_phase == 4'd0 &&
          int'(kept_cols) < span &&
          tx + int'(kept_cols) < int'(stride) &&
          ty + int'(kept_rows) < DISP_H) begin
        addr = int'(row_base) + ty * int'(stride) + tx + int'(kept_cols);
        wr.write_address = addr[19:0];
        wr.write_color   = px.pixel_color;
        expected_writes.push_back(wr);
      end

      if (col_in) begin
        if (col_phase == 4'd0 && kept_cols < CNT_MAX) kept_cols = kept_cols + 11'd1;
        col_phase = (int'(col_phase) + 1 >= f) ? 4'd0 : col_phase + 4'd1;
      end

      if (int'(col) + 1 >= w) begin
        col       = '0;
        col_phase = '0;
        kept_cols = '0;
        if (row_in) begin
          if (row_phase == 4'd0) begin
            if (kept_rows < CNT_MAX) kept_rows = kept_rows + 11'd1;
            row_base = row_base + 20'(stride);
          end
          row_phase = (int'(row_phase) + 1 >= f) ? 4'd0 : row_phase + 4'd1;
        end
        if (int'(row) + 1 >= h) clear_position();
        else row = row + 11'd1;
      end else begin
        col = col + 11'd1;
      end
    endfunction

    function void check_write(out_t got);
      out_t exp_wr;
      if (expected_writes.size() == 0) begin
        errors++;
        $display("%0t: unexpected write: expected none, actual addr %h colour %h",
                 $time, got.write_address, got.write_color);
        return;
      end
      exp_wr = expected_writes.pop_front();
      if (got.write_address !== exp_wr.write_address) begin
        errors++;
        $display("%0t: write_address mismatch: expected %h, actual %h",
                 $time, exp_wr.write_address, got.write_address);
      end
      if (got.write_color !== exp_wr.write_color) begin
        errors++;
        $display("%0t: write_color mismatch: expected %h, actual %h",
                 $time, exp_wr.write_color, got.write_color);
      end
    endfunction
  endclass

endpackage

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench for clipped_decimating_blit_top: drives pixel, write
// and register channels. Depends on cdb_pkg and tb_blit_pkg.
module tb_top;
  import cdb_pkg::*;
  import tb_blit_pkg::*;

  localparam int RANDOM_ITEMS = 1350;
  localparam int SETTLE       = 8;    // cycles after the last write before a cfg change
  localparam int HOLD_CYCLES  = 80;   // long sink hold-off to back the block up

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  blit_write_tracker writes = new();

  // idling control, shared between the driver and the sink process
  int send_idle_pct;
  int sink_stall_pct;
  bit hold_request;
  int hold_left;

  // effective image size of the current setting, for shaping images
  int cur_w, cur_h;
  int random_sent;

  clipped_decimating_blit_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Sink side: random stalls, plus one long hold-off counted here when the
  // stimulus asks for it. Driven on the falling edge like everything else.
  initial begin : sink
    bit hold_done;
    hold_done = 1'b0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  // Write monitor: every accepted write transaction goes to the tracker.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) writes.check_write(out_data);
  end

  // 0: no idling, 1: sender idles, 2: sink stalls, 3: both, lightly
  task automatic set_idling(input int mode);
    case (mode)
      1:       begin send_idle_pct = 58; sink_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  sink_stall_pct = 58; end
      3:       begin send_idle_pct = 15; sink_stall_pct = 15; end
      default: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
    endcase
  endtask

  // One pixel transaction. Valid is only dropped for an idle gap, never
  // toggled within a step.
  task automatic send_pixel(input logic [15:0] colour, input logic soi);
    in_t px;
    px.pixel_color    = colour;
    px.start_of_image = soi;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
    writes.accept_pixel(px);
  endtask

  // Stop offering pixels and let every expected write come out, then give
  // the pipeline a few more cycles for pixels that write nothing.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (writes.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    writes.write_reg(idx, val);
  endtask

  // Full register set, only ever applied with the block idle.
  task automatic apply_config(input logic [11:0] dx, input logic [11:0] dy,
                              input logic [11:0] w, input logic [11:0] h,
                              input logic [11:0] zf, input logic [11:0] bw);
    drain();
    write_reg(CFG_DEST_X, dx);
    write_reg(CFG_DEST_Y, dy);
    write_reg(CFG_SRC_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_ZOOM_FACTOR, zf);
    write_reg(CFG_ROW_STRIDE, bw);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_w = clamp_size(w);
    cur_h = clamp_size(h);
  endtask

  // Random origin: mostly on screen or slightly off the top/left edge.
  function automatic logic [11:0] pick_offset();
    case ($urandom_range(0, 9))
      0:       return 12'h800;
      1:       return 12'h7FF;
      2:       return 12'($urandom());
      3, 4:    return 12'd0 - 12'($urandom_range(1, 12));
      default: return 12'($urandom_range(0, 470));
    endcase
  endfunction

  function automatic logic [11:0] pick_size();
    case ($urandom_range(0, 19))
      0:       return 12'd0;
      1:       return SIZE_MAX;
      2:       return 12'($urandom_range(2049, 4095));
      3:       return 12'($urandom_range(21, 600));
      default: return 12'($urandom_range(1, 20));
    endcase
  endfunction

  // Upper cfg_data bits are junk for the 5-bit zoom register.
  function automatic logic [11:0] pick_zoom();
    case ($urandom_range(0, 9))
      0:       return 12'd0;
      1:       return 12'(FACTOR_MAX);
      2:       return 12'($urandom_range(17, 31));
      3:       return {7'($urandom()), 5'($urandom_range(1, 4))};
      default: return 12'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [11:0] pick_stride();
    case ($urandom_range(0, 9))
      0:       return 12'd0;
      1:       return 12'hFFF;
      2:       return 12'($urandom());
      3, 4, 5: return 12'(DISP_W);
      default: return 12'($urandom_range(1, 600));
    endcase
  endfunction

  initial begin : stimulus
    int phase, budget, n, len, i;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_DEST_X;
    cfg_data  = '0;
    hold_request = 1'b0;
    cur_w = 1;
    cur_h = 1;
    random_sent = 0;
    set_idling(0);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Reset setting: 1x1 image, every pixel lands on 0.
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h5A5A, 1'b1);

    // Negative origin on both axes, zoom factor zero acting as one.
    apply_config(12'hFFE, 12'hFFF, 12'd3, 12'd2, 12'd0, 12'(DISP_W));
    for (i = 0; i < 6; i++) send_pixel(16'($urandom()), i == 0);

    // Origin far right so the row span is empty; zoom above sixteen,
    // zero width, oversize height and zero stride all at once.
    apply_config(12'h7FF, 12'd0, 12'd0, 12'hFFF, 12'd31, 12'd0);
    for (i = 0; i < 3; i++) send_pixel(16'($urandom()), i == 0);

    // Zero stride alone: nothing passes the right clip.
    apply_config(12'd0, 12'd0, 12'd2, 12'd1, 12'd1, 12'd0);
    for (i = 0; i < 2; i++) send_pixel(16'($urandom()), i == 0);

    // Bottom display row with a huge stride: the address wraps.
    apply_config(12'd0, 12'd479, 12'd5, 12'd1, 12'd1, 12'hFFF);
    for (i = 0; i < 3; i++) send_pixel(16'($urandom()), i == 0);

    // Running past the end of a 2x2 image with no new start marker.
    apply_config(12'd1, 12'd1, 12'd2, 12'd2, 12'd2, 12'(DISP_W));
    for (i = 0; i < 6; i++) send_pixel(16'($urandom()), i == 0);

    // Random part: each phase a new setting and idling style, mostly whole
    // images with random content, the rest truncated or noisy sequences.
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (phase == 2) begin
        // every pixel written, so the long hold-off really backs the block up
        apply_config(12'd0, 12'd0, 12'd8, 12'd8, 12'd1, 12'(DISP_W));
      end else begin
        apply_config(pick_offset(), pick_offset(), pick_size(), pick_size(),
                     pick_zoom(), pick_stride());
      end
      set_idling(phase % 4);
      if (phase == 2) hold_request = 1'b1;
      budget = $urandom_range(40, 120);
      n = 0;
      while (n < budget) begin
        if (cur_w * cur_h <= 200 && $urandom_range(0, 4) != 0) begin
          len = cur_w * cur_h;
          for (i = 0; i < len; i++) send_pixel(16'($urandom()), i == 0);
        end else begin
          len = $urandom_range(1, 30);
          for (i = 0; i < len; i++)
            send_pixel(16'($urandom()),
                       (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) == 0));
        end
        n += len;
      end
      random_sent += n;
      phase++;
    end

    drain();
    repeat (20) @(posedge clk);
    if (writes.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
